>>> rtl/core/bts_pkg.sv
package bts_pkg;

  // image store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = XW + YW;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  // field widths
  localparam int DIM_W   = 9;
  localparam int CHAN_W  = 16;
  localparam int COORD_W = 16;
  localparam int FRAC_W  = COORD_W;
  localparam int FX_W    = COORD_W + XW;
  localparam int FY_W    = COORD_W + YW;

  // blend datapath widths: offset below 2.0, signed weights, signed products
  localparam int DELTA_W  = FRAC_W + 2;
  localparam int WGT_W    = 2 * DELTA_W;
  localparam int PROD_W   = WGT_W + CHAN_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ROUND_SH = 2 * FRAC_W;

  // smallest usable image dimension
  localparam int DIM_MIN = 2;
  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [1:0] corner;
  } blend_ctl_t;

  // clamp a configured dimension into the usable range
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(DIM_MIN)) begin
      r = DIM_W'(DIM_MIN);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bts_if.sv
interface bts_in_if;
  import bts_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [XW-1:0]      pixel_x;
  logic [YW-1:0]      pixel_y;
  logic [CHAN_W-1:0]  write_red;
  logic [CHAN_W-1:0]  write_green;
  logic [CHAN_W-1:0]  write_blue;
  logic [COORD_W-1:0] coord_u;
  logic [COORD_W-1:0] coord_v;
  logic               use_bilinear;

  modport source (output valid, opcode, pixel_x, pixel_y, write_red, write_green,
                  write_blue, coord_u, coord_v, use_bilinear, input ready);
  modport sink (input valid, opcode, pixel_x, pixel_y, write_red, write_green,
                write_blue, coord_u, coord_v, use_bilinear, output ready);
endinterface

interface bts_out_if;
  import bts_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              in_range;

  modport source (output valid, out_red, out_green, out_blue, in_range, input ready);
  modport sink (input valid, out_red, out_green, out_blue, in_range, output ready);
endinterface

interface bts_cfg_if;
  import bts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/bts_blend.sv
module bts_blend (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bts_pkg::blend_ctl_t        ctl,
  input  logic [bts_pkg::DELTA_W-1:0] dx,
  input  logic [bts_pkg::DELTA_W-1:0] dy,
  input  bts_pkg::pixel_t            texel,
  output logic                       busy,
  output bts_pkg::pixel_t            result
);
  import bts_pkg::*;

  localparam logic [DELTA_W-1:0] ONE  = DELTA_W'(1) << FRAC_W;
  localparam logic [ACC_W-1:0]   HALF = ACC_W'(1) << (ROUND_SH - 1);
  localparam int                 RW   = ACC_W - ROUND_SH;
  localparam logic [RW-1:0]      CMAX = RW'({CHAN_W{1'b1}});

  logic signed [DELTA_W-1:0] fac_x;
  logic signed [DELTA_W-1:0] fac_y;
  logic signed [WGT_W-1:0]   wgt_nxt;
  logic signed [WGT_W-1:0]   wgt_r;
  logic                      wv_r;
  logic                      pv_r;
  logic [CHAN_W-1:0]         chan [3];
  logic signed [PROD_W-1:0]  prod_nxt [3];
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [ACC_W-1:0]   acc_r [3];
  logic [CHAN_W-1:0]         res [3];

  // corner weight: (1-dx) or dx times (1-dy) or dy
  always_comb begin
    fac_x   = ctl.corner[0] ? $signed(dx) : $signed(ONE - dx);
    fac_y   = ctl.corner[1] ? $signed(dy) : $signed(ONE - dy);
    wgt_nxt = WGT_W'(fac_x) * WGT_W'(fac_y);
  end

  assign chan[0] = texel.red;
  assign chan[1] = texel.green;
  assign chan[2] = texel.blue;

  // one multiplier per channel lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = PROD_W'(wgt_r) * PROD_W'($signed({1'b0, chan[i]}));
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      wv_r <= ctl.load;
      pv_r <= wv_r;
    end
  end

  // weight, product and accumulator registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      wgt_r <= wgt_nxt;
    end
    if (wv_r) begin
      prod_r <= prod_nxt;
    end
    for (int i = 0; i < 3; i++) begin
      if (ctl.clear) begin
        acc_r[i] <= '0;
      end else if (pv_r) begin
        acc_r[i] <= acc_r[i] + ACC_W'(prod_r[i]);
      end
    end
  end

  // round half up, dropping the 32 weight fraction bits, and saturate
  always_comb begin
    logic [ACC_W-1:0] rnd;
    logic [RW-1:0]    top;
    for (int i = 0; i < 3; i++) begin
      rnd = $unsigned(acc_r[i]) + HALF;
      top = rnd[ACC_W-1:ROUND_SH];
      if (acc_r[i][ACC_W-1]) begin
        res[i] = '0;
      end else if (top > CMAX) begin
        res[i] = {CHAN_W{1'b1}};
      end else begin
        res[i] = top[CHAN_W-1:0];
      end
    end
  end

  assign result = '{red: res[0], green: res[1], blue: res[2]};
  assign busy   = wv_r | pv_r;

endmodule

>>> rtl/core/bilinear_texture_sampler_unit.sv
// Bilinear texture sampler: an RGB image of 256 by 256 pixels, channels Q4.12.
// Input channel (in_chan) carries one operation per item: write a pixel, read
// a pixel, or sample at normalized u,v (nearest or bilinear). Every item gives
// exactly one result item on out_chan: colour and an in_range flag.
// Configuration channel (cfg_chan) sets image width and height; it is always
// ready, and the user must see that it is written only while no item is in
// flight; the block itself does not enforce this. A write, read, nearest
// sample or the unused opcode goes from accept through execute to output; a
// bilinear sample makes four reads through the single pixel memory port and
// then drains a weight, multiply and accumulate pipeline before its output.
// One item is in flight at a time: a new item is taken only once the last
// one's result has been loaded into the output register.
// The result sits in an output register; when the receiver stalls, the
// next item is still accepted and processed, and it waits for that register
// to drain before its own result is loaded.
// Reset clears the control state and sets width and height to 256; pixel
// memory contents are undefined after reset until written.
module bilinear_texture_sampler_unit (
  input logic       clk,
  input logic       rst_n,
  bts_in_if.sink    in_chan,
  bts_out_if.source out_chan,
  bts_cfg_if.sink   cfg_chan
);
  import bts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FETCH, S_DRAIN, S_OUT} state_t;
  typedef enum logic [1:0] {SRC_ZERO, SRC_MEM, SRC_BLEND} src_t;

  state_t                   state_r, state_nxt;
  src_t                     src_r, src_nxt;
  logic                     range_r, range_nxt;
  logic [1:0]               corner_r;
  logic [DIM_W-1:0]         width_r, height_r;
  logic [DIM_W-1:0]         w_eff, h_eff;
  logic                     in_fire;
  logic                     out_free;

  opcode_t                  op_r;
  logic [XW-1:0]            px_r;
  logic [YW-1:0]            py_r;
  pixel_t                   wr_pix_r;
  logic                     bil_r;
  logic                     inside_r;
  logic [COORD_W+DIM_W-1:0] fx_full, fy_full;
  logic [FX_W-1:0]          fx_r;
  logic [FY_W-1:0]          fy_r;

  logic [XW-1:0]            ix, lx_nxt, lx_r;
  logic [YW-1:0]            iy, ly_nxt, ly_r;
  logic [DIM_W-1:0]         w_m2, h_m2;
  logic [FX_W-1:0]          dx_full;
  logic [FY_W-1:0]          dy_full;
  logic [DELTA_W-1:0]       dx_r, dy_r;

  pixel_t                   mem [DEPTH];
  logic [ADDR_W-1:0]        mem_addr;
  logic                     mem_we, mem_re;
  pixel_t                   rd_pix_r;

  blend_ctl_t               blend_ctl;
  logic                     blend_busy;
  pixel_t                   blend_res;

  logic                     out_valid_r;
  pixel_t                   out_pix_r, out_pix_nxt;
  logic                     out_range_r;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= MAX_W_DIM;
      height_r <= MAX_H_DIM;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_chan.data;
        REG_IMAGE_HEIGHT: height_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_dim(width_r, MAX_W_DIM);
  assign h_eff = clamp_dim(height_r, MAX_H_DIM);

  // input capture: scale u,v by the image size on the way in
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign fx_full       = (COORD_W+DIM_W)'(in_chan.coord_u) * (COORD_W+DIM_W)'(w_eff);
  assign fy_full       = (COORD_W+DIM_W)'(in_chan.coord_v) * (COORD_W+DIM_W)'(h_eff);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= opcode_t'(in_chan.opcode);
      px_r     <= in_chan.pixel_x;
      py_r     <= in_chan.pixel_y;
      wr_pix_r <= '{red: in_chan.write_red, green: in_chan.write_green,
                    blue: in_chan.write_blue};
      bil_r    <= in_chan.use_bilinear;
      inside_r <= (DIM_W'(in_chan.pixel_x) < w_eff) && (DIM_W'(in_chan.pixel_y) < h_eff);
      fx_r     <= fx_full[FX_W-1:0];
      fy_r     <= fy_full[FY_W-1:0];
    end
  end

  // base corner clamped to width-2, height-2, and offsets from it
  assign ix      = fx_r[FX_W-1:FRAC_W];
  assign iy      = fy_r[FY_W-1:FRAC_W];
  assign w_m2    = w_eff - DIM_W'(DIM_MIN);
  assign h_m2    = h_eff - DIM_W'(DIM_MIN);
  assign lx_nxt  = (DIM_W'(ix) < w_m2) ? ix : w_m2[XW-1:0];
  assign ly_nxt  = (DIM_W'(iy) < h_m2) ? iy : h_m2[YW-1:0];
  assign dx_full = fx_r - {lx_nxt, FRAC_W'(0)};
  assign dy_full = fy_r - {ly_nxt, FRAC_W'(0)};

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      lx_r <= lx_nxt;
      ly_r <= ly_nxt;
      dx_r <= dx_full[DELTA_W-1:0];
      dy_r <= dy_full[DELTA_W-1:0];
    end
  end

  // memory port address and enables
  always_comb begin
    mem_addr = {py_r, px_r};
    case (state_r)
      S_EXEC: begin
        if (op_r == OP_SAMPLE) begin
          mem_addr = {iy, ix};
        end
      end
      S_FETCH: mem_addr = {ly_r + YW'(corner_r[1]), lx_r + XW'(corner_r[0])};
      default: ;
    endcase
  end

  assign mem_we = (state_r == S_EXEC) && (op_r == OP_WRITE) && inside_r;
  assign mem_re = ((state_r == S_EXEC) &&
                   (((op_r == OP_READ) && inside_r) || ((op_r == OP_SAMPLE) && !bil_r))) ||
                  (state_r == S_FETCH);

  // pixel memory, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_pix_r;
    end
    if (mem_re) begin
      rd_pix_r <= mem[mem_addr];
    end
  end

  // weighted blend of the four corners
  assign blend_ctl = '{clear: (state_r == S_EXEC), load: (state_r == S_FETCH),
                       corner: corner_r};

  bts_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (blend_ctl),
    .dx     (dx_r),
    .dy     (dy_r),
    .texel  (rd_pix_r),
    .busy   (blend_busy),
    .result (blend_res)
  );

  // sequencer next state
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    range_nxt = range_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        case (op_r)
          OP_WRITE: begin
            src_nxt   = SRC_ZERO;
            range_nxt = inside_r;
          end
          OP_READ: begin
            src_nxt   = inside_r ? SRC_MEM : SRC_ZERO;
            range_nxt = inside_r;
          end
          OP_SAMPLE: begin
            range_nxt = 1'b1;
            if (bil_r) begin
              src_nxt   = SRC_BLEND;
              state_nxt = S_FETCH;
            end else begin
              src_nxt = SRC_MEM;
            end
          end
          default: begin
            src_nxt   = SRC_ZERO;
            range_nxt = 1'b0;
          end
        endcase
      end
      S_FETCH: begin
        if (corner_r == 2'd3) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!blend_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    case (src_r)
      SRC_MEM:   out_pix_nxt = rd_pix_r;
      SRC_BLEND: out_pix_nxt = blend_res;
      default:   out_pix_nxt = '0;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      src_r       <= SRC_ZERO;
      range_r     <= 1'b0;
      corner_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
      range_r <= range_nxt;
      if (state_r == S_FETCH) begin
        corner_r <= corner_r + 2'd1;
      end else begin
        corner_r <= '0;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        out_pix_r   <= out_pix_nxt;
        out_range_r <= range_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_red   = out_pix_r.red;
  assign out_chan.out_green = out_pix_r.green;
  assign out_chan.out_blue  = out_pix_r.blue;
  assign out_chan.in_range  = out_range_r;

`ifndef SYNTH
  // blend pipeline only runs while a bilinear sample is fetched or drained
  a_blend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    blend_busy |-> (state_r == S_FETCH || state_r == S_DRAIN))
    else $error("blend pipeline active outside fetch or drain");

  // memory is written only by an in-image pixel write
  a_write_guard: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (inside_r && op_r == OP_WRITE && state_r == S_EXEC))
    else $error("pixel memory written without an in-image write");

  // the fourth corner read ends the fetch phase
  a_fetch_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH && corner_r == 2'd3) |=> (state_r == S_DRAIN))
    else $error("fetch phase did not end after four reads");

  // a result is loaded only when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> $stable(out_pix_r) && $stable(out_range_r))
    else $error("stalled result overwritten");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

import bts_pkg::*;

// one operation offered to the sampler
typedef struct packed {
  opcode_t            op;
  logic [XW-1:0]      px;
  logic [YW-1:0]      py;
  pixel_t             color;
  logic [COORD_W-1:0] u;
  logic [COORD_W-1:0] v;
  logic               bilinear;
} texel_req_t;

// one result returned by the sampler
typedef struct packed {
  pixel_t color;
  logic   in_range;
} texel_rsp_t;

// image mirror, colour predictor and queue of colors still to arrive
class texel_scoreboard;
  pixel_t           texels [int unsigned];
  logic [15:0]      written_xy [$];
  logic [DIM_W-1:0] width_reg = MAX_W_DIM;
  logic [DIM_W-1:0] height_reg = MAX_H_DIM;
  texel_rsp_t       expected_colors [$];
  int               errors = 0;

  function int unsigned eff_size(logic [DIM_W-1:0] v, int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  function int unsigned eff_w();
    return eff_size(width_reg, MAX_WIDTH);
  endfunction

  function int unsigned eff_h();
    return eff_size(height_reg, MAX_HEIGHT);
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = val;
      REG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endfunction

  function int unsigned slot(int unsigned x, int unsigned y);
    return y * MAX_WIDTH + x;
  endfunction

  function bit written(int unsigned x, int unsigned y);
    return texels.exists(slot(x, y));
  endfunction

  function pixel_t texel(int unsigned x, int unsigned y);
    if (written(x, y)) return texels[slot(x, y)];
    return '0;
  endfunction

  // scaled position and the texels a sample touches (corner 0 is the base)
  function void footprint(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                          input logic bil, output int unsigned fx, output int unsigned fy,
                          output int unsigned xs [4], output int unsigned ys [4]);
    int unsigned ix, iy, lx, ly, sx;
    fx = u * eff_w();
    fy = v * eff_h();
    ix = fx >> FRAC_W;
    iy = fy >> FRAC_W;
    // bilinear base corner is held back from the last column and row
    lx = (bil && ix > eff_w() - 2) ? eff_w() - 2 : ix;
    ly = (bil && iy > eff_h() - 2) ? eff_h() - 2 : iy;
    sx = bil ? 1 : 0;
    xs = '{lx, lx + sx, lx, lx + sx};
    ys = '{ly, ly, ly + sx, ly + sx};
  endfunction

  // update the mirror and work out the result of one item
  function texel_rsp_t apply_request(texel_req_t rq);
    texel_rsp_t  rs;
    int unsigned fx, fy;
    int unsigned xs [4];
    int unsigned ys [4];
    pixel_t      corner [4];
    longint      dx, dy, acc, chan;
    longint      wt [4];
    logic [CHAN_W-1:0] ch;
    bit          in_image;
    int          c, k;
    rs = '0;
    in_image = rq.px < eff_w() && rq.py < eff_h();
    case (rq.op)
      OP_WRITE: begin
        if (in_image) begin
          if (!written(rq.px, rq.py)) written_xy.push_back({rq.py, rq.px});
          texels[slot(rq.px, rq.py)] = rq.color;
        end
        rs.in_range = in_image;
      end
      OP_READ: begin
        if (in_image) rs.color = texel(rq.px, rq.py);
        rs.in_range = in_image;
      end
      OP_SAMPLE: begin
        rs.in_range = 1'b1;
        footprint(rq.u, rq.v, rq.bilinear, fx, fy, xs, ys);
        if (!rq.bilinear) begin
          rs.color = texel(xs[0], ys[0]);
        end else begin
          // offsets may pass 1.0 at the far edge, so weights go negative
          dx = longint'(fx) - longint'(xs[0]) * 65536;
          dy = longint'(fy) - longint'(ys[0]) * 65536;
          wt[0] = (65536 - dx) * (65536 - dy);
          wt[1] = dx * (65536 - dy);
          wt[2] = (65536 - dx) * dy;
          wt[3] = dx * dy;
          for (k = 0; k < 4; k++) corner[k] = texel(xs[k], ys[k]);
          for (c = 0; c < 3; c++) begin
            acc = 0;
            for (k = 0; k < 4; k++) begin
              ch = corner[k][CHAN_W*(2-c) +: CHAN_W];
              chan = ch;
              acc += wt[k] * chan;
            end
            // round half up, dropping the 32 weight fraction bits, clip to the channel range
            if (acc < 0) begin
              acc = 0;
            end else begin
              acc = (acc + 64'sh8000_0000) >>> ROUND_SH;
              if (acc > 65535) acc = 65535;
            end
            rs.color[CHAN_W*(2-c) +: CHAN_W] = acc[CHAN_W-1:0];
          end
        end
      end
      OP_NONE: ;
      default: ;
    endcase
    return rs;
  endfunction

  function void log_request(texel_req_t rq);
    expected_colors.push_back(apply_request(rq));
  endfunction

  function int pending();
    return expected_colors.size();
  endfunction

  function void compare_field(string field, logic [CHAN_W-1:0] want,
                              logic [CHAN_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endfunction

  function void check_color(texel_rsp_t got);
    texel_rsp_t want;
    if (expected_colors.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, actual %h %h %h in_range %b", $time,
               got.color.red, got.color.green, got.color.blue, got.in_range);
      return;
    end
    want = expected_colors.pop_front();
    compare_field("red", want.color.red, got.color.red);
    compare_field("green", want.color.green, got.color.green);
    compare_field("blue", want.color.blue, got.color.blue);
    compare_field("in_range", want.in_range, got.in_range);
  endfunction

  function void report_leftover();
    if (expected_colors.size() > 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected next %h %h %h in_range %b",
               $time, expected_colors.size(), expected_colors[0].color.red,
               expected_colors[0].color.green, expected_colors[0].color.blue,
               expected_colors[0].in_range);
    end
  endfunction
endclass

module tb;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 120;

  logic clk;
  logic rst_n;

  bts_in_if  in_chan ();
  bts_out_if out_chan ();
  bts_cfg_if cfg_chan ();

  bilinear_texture_sampler_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  texel_scoreboard colors = new();

  int cycle_count = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;
  logic [DIM_W-1:0] phase_w [PHASES];
  logic [DIM_W-1:0] phase_h [PHASES];

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAN_W-1:0] random_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // coordinate whose scaled integer part lands on texel t of n
  function automatic logic [COORD_W-1:0] aim(int unsigned t, int unsigned n);
    int unsigned lo, hi;
    lo = (t * 65536 + n - 1) / n;
    hi = ((t + 1) * 65536 + n - 1) / n - 1;
    if (hi > 65535) hi = 65535;
    return COORD_W'($urandom_range(hi, lo));
  endfunction

  function automatic texel_req_t make_req(opcode_t op, logic [XW-1:0] x, logic [YW-1:0] y,
                                          pixel_t c, logic [COORD_W-1:0] u,
                                          logic [COORD_W-1:0] v, logic bil);
    texel_req_t rq;
    rq.op = op;
    rq.px = x;
    rq.py = y;
    rq.color = c;
    rq.u = u;
    rq.v = v;
    rq.bilinear = bil;
    return rq;
  endfunction

  // random item; reads and samples only touch texels already written
  function automatic texel_req_t pick_request();
    texel_req_t  rq;
    int unsigned w, h, r, fx, fy;
    int unsigned xs [4];
    int unsigned ys [4];
    logic [XW-1:0] tx;
    logic [YW-1:0] ty;
    int          k;
    rq.color.red = random_chan();
    rq.color.green = random_chan();
    rq.color.blue = random_chan();
    rq.px = XW'($urandom);
    rq.py = YW'($urandom);
    rq.u = COORD_W'($urandom);
    rq.v = COORD_W'($urandom);
    rq.bilinear = 1'($urandom);
    rq.op = OP_NONE;
    w = colors.eff_w();
    h = colors.eff_h();
    r = $urandom_range(0, 99);
    if (r < 20) begin
      rq.op = OP_WRITE;
      if ($urandom_range(0, 99) < 85) begin
        rq.px = XW'($urandom_range(w - 1, 0));
        rq.py = YW'($urandom_range(h - 1, 0));
      end
    end else if (r < 40) begin
      rq.op = OP_READ;
      if ((rq.px < w && rq.py < h && !colors.written(rq.px, rq.py)) ||
          $urandom_range(0, 1)) begin
        {rq.py, rq.px} = colors.written_xy[$urandom_range(colors.written_xy.size() - 1, 0)];
      end
    end else if (r < 97) begin
      rq.op = OP_SAMPLE;
      rq.bilinear = $urandom_range(0, 99) < 65;
      if ($urandom_range(0, 99) < 60) begin
        {ty, tx} = colors.written_xy[$urandom_range(colors.written_xy.size() - 1, 0)];
        if (tx < w && ty < h) begin
          rq.u = aim(tx, w);
          rq.v = aim(ty, h);
        end
      end
      // a missing texel is written first instead of sampled
      colors.footprint(rq.u, rq.v, rq.bilinear, fx, fy, xs, ys);
      for (k = 0; k < 4; k++) begin
        if (!colors.written(xs[k], ys[k])) begin
          rq.op = OP_WRITE;
          rq.px = XW'(xs[k]);
          rq.py = YW'(ys[k]);
        end
      end
    end
    return rq;
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_item(input texel_req_t rq);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 99) < 3) burst_left = 40;
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.opcode <= rq.op;
    in_chan.pixel_x <= rq.px;
    in_chan.pixel_y <= rq.py;
    in_chan.write_red <= rq.color.red;
    in_chan.write_green <= rq.color.green;
    in_chan.write_blue <= rq.color.blue;
    in_chan.coord_u <= rq.u;
    in_chan.coord_v <= rq.v;
    in_chan.use_bilinear <= rq.bilinear;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    colors.log_request(rq);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    int n;
    in_chan.valid <= 1'b0;
    n = 0;
    while (colors.pending() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= REG_IMAGE_WIDTH;
    cfg_chan.data <= w;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    colors.set_reg(REG_IMAGE_WIDTH, w);
    cfg_chan.index <= REG_IMAGE_HEIGHT;
    cfg_chan.data <= h;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    colors.set_reg(REG_IMAGE_HEIGHT, h);
    cfg_chan.valid <= 1'b0;
  endtask

  // result receiver: random stalls, bursts, and one long hold on request
  initial begin : result_sink
    int gap, run;
    bit held;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      run = ($urandom_range(0, 99) < 4) ? 80 : $urandom_range(8, 1);
      repeat (run) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    texel_rsp_t got;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.color.red = out_chan.out_red;
      got.color.green = out_chan.out_green;
      got.color.blue = out_chan.out_blue;
      got.in_range = out_chan.in_range;
      colors.check_color(got);
    end
  end

  initial begin : stimulus
    int p, i;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.opcode <= OP_WRITE;
    in_chan.pixel_x <= '0;
    in_chan.pixel_y <= '0;
    in_chan.write_red <= '0;
    in_chan.write_green <= '0;
    in_chan.write_blue <= '0;
    in_chan.coord_u <= '0;
    in_chan.coord_v <= '0;
    in_chan.use_bilinear <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= REG_IMAGE_WIDTH;
    cfg_chan.data <= '0;
    phase_w = '{9'd2, 9'd511, 9'd5, 9'd16, 9'd0, 9'd200, 9'd256};
    phase_h = '{9'd2, 9'd3, 9'd511, 9'd9, 9'd1, 9'd37, 9'd256};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // full image after reset: the four corners around both ends of the store
    send_item(make_req(OP_WRITE, 0, 0, '{16'hFFFF, 16'h0000, 16'h8000}, 0, 0, 0));
    send_item(make_req(OP_WRITE, 1, 0, '{16'h0000, 16'hFFFF, 16'h1234}, 0, 0, 0));
    send_item(make_req(OP_WRITE, 0, 1, '{16'h8000, 16'h8000, 16'hFFFF}, 0, 0, 0));
    send_item(make_req(OP_WRITE, 1, 1, '{16'hFFFF, 16'hFFFF, 16'h0000}, 0, 0, 0));
    send_item(make_req(OP_WRITE, 254, 254, '{16'hFFFF, 16'h0000, 16'hFFFF}, 0, 0, 0));
    send_item(make_req(OP_WRITE, 255, 254, '{16'h0000, 16'hFFFF, 16'h0000}, 0, 0, 0));
    send_item(make_req(OP_WRITE, 254, 255, '{16'h0000, 16'hFFFF, 16'hFFFF}, 0, 0, 0));
    send_item(make_req(OP_WRITE, 255, 255, '{16'hFFFF, 16'h0000, 16'h0000}, 0, 0, 0));
    send_item(make_req(OP_READ, 0, 0, '0, 0, 0, 0));
    send_item(make_req(OP_READ, 255, 255, '0, 0, 0, 0));
    send_item(make_req(OP_SAMPLE, 0, 0, '0, 16'h0000, 16'h0000, 0));
    send_item(make_req(OP_SAMPLE, 0, 0, '0, 16'h0000, 16'h0000, 1));
    send_item(make_req(OP_SAMPLE, 0, 0, '0, 16'h00C0, 16'h0080, 1));
    send_item(make_req(OP_SAMPLE, 0, 0, '0, 16'hFFFF, 16'hFFFF, 0));
    // far corner: extrapolating blend saturates high and low
    send_item(make_req(OP_SAMPLE, 0, 0, '0, 16'hFFFF, 16'hFFFF, 1));
    send_item(make_req(OP_NONE, 255, 255, '1, 16'hFFFF, 16'hFFFF, 1));

    // sizes below the minimum clamp to a 2 by 2 image
    drain();
    write_regs(9'd1, 9'd0);
    send_item(make_req(OP_WRITE, 2, 0, '1, 0, 0, 0));
    send_item(make_req(OP_WRITE, 0, 2, '1, 0, 0, 0));
    send_item(make_req(OP_READ, 5, 0, '0, 0, 0, 0));
    send_item(make_req(OP_READ, 1, 1, '0, 0, 0, 0));
    send_item(make_req(OP_SAMPLE, 0, 0, '0, 16'hFFFF, 16'hFFFF, 1));
    send_item(make_req(OP_SAMPLE, 0, 0, '0, 16'h8000, 16'h8000, 0));
    send_item(make_req(OP_WRITE, 1, 0, '{16'h0FFF, 16'hF000, 16'h5A5A}, 0, 0, 0));

    // random phases over a range of image sizes
    for (p = 0; p < PHASES; p++) begin
      drain();
      write_regs(phase_w[p], phase_h[p]);
      if (p == 2) hold_request = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) send_item(pick_request());
    end

    drain();
    colors.report_leftover();
    if (colors.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
